// ----- design/wbps_pkg.sv -----
package wbps_pkg;

    // Pattern storage and counter sizes.
    localparam int PATTERN_MAX = 64;
    localparam int IDX_BITS    = $clog2(PATTERN_MAX);
    localparam int LEN_BITS    = 7;
    localparam int OFFSET_BITS = 32;
    localparam int ADDR_BITS   = 48;

    // Command codes carried by the cmd field.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_PATTERN_LENGTH = 1'b0;
    localparam logic CFG_BASE_ADDRESS   = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_FOUND    = 2'd1,
        ST_END_MISS = 2'd2,
        ST_END_HIT  = 2'd3
    } status_t;

endpackage

// ----- design/wildcard_byte_pattern_scanner_top.sv -----
// Streaming wildcard byte pattern search. Each input beat either loads one
// pattern entry (cmd = load) or scans one data byte (cmd = scan), and every
// input beat yields exactly one result beat in the following cycle. The block takes
// one beat per cycle: a single register stage after the 64 parallel byte
// comparators and the shift-and prefix vector sets that figure. A new beat
// enters whenever the result register is empty or its beat is taken in the
// same cycle, so a result left waiting holds off the input until it is taken.
// The first full match reports status 1 with the start offset and
// base_address plus that offset; the scan beat flagged last_byte reports status 2
// or 3 and clears the match state. Write pattern_length and base_address only
// while no beat is in flight; entries covered by pattern_length must have been
// loaded before they are scanned.
module wildcard_byte_pattern_scanner_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [wbps_pkg::ADDR_BITS-1:0]        cfg_data,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [wbps_pkg::IDX_BITS-1:0]         entry_index,
    input  logic [7:0]                            entry_value,
    input  logic                                  entry_wildcard,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,
    // Result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [wbps_pkg::OFFSET_BITS-1:0]      match_offset,
    output logic [wbps_pkg::ADDR_BITS-1:0]        match_address
);

    import wbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // Configuration registers
    logic [LEN_BITS-1:0]    pattern_length_reg;
    logic [ADDR_BITS-1:0]   base_address_reg;

    // Pattern store, no reset: each entry feeds its own comparator.
    logic [7:0]             pattern_values_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] wildcard_marks_reg;

    // Scan state
    logic [PATTERN_MAX-1:0] partial_bits_reg, partial_bits_next;
    logic [OFFSET_BITS-1:0] byte_position_reg, byte_position_next;
    logic                   match_seen_reg, match_seen_next;
    logic [OFFSET_BITS-1:0] first_offset_reg, first_offset_next;

    // Result register
    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [ADDR_BITS-1:0]   address_reg, address_next;

    logic                   in_beat;
    logic                   scan_beat;
    logic [PATTERN_MAX-1:0] hit_mask;
    logic                   len_ok;
    logic [IDX_BITS-1:0]    top_idx;
    logic                   full_hit;
    logic [OFFSET_BITS-1:0] new_offset;
    logic [OFFSET_BITS-1:0] report_offset;

    // Handshakes: the result register frees up when it is empty or being taken.
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign scan_beat = in_beat && (cmd == CMD_SCAN);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            base_address_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_BITS-1:0];
                CFG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                default:            pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    // Pattern entry loads.
    always_ff @(posedge clk)
    begin
        if (in_beat && (cmd == CMD_LOAD))
        begin
            pattern_values_reg[entry_index] <= entry_value;
            wildcard_marks_reg[entry_index] <= entry_wildcard;
        end
    end

    // Per-position match mask, limited to the active pattern length.
    always_comb
    begin
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            hit_mask[p] = (LEN_BITS'(p) < pattern_length_reg) &&
                          (wildcard_marks_reg[p] || (pattern_values_reg[p] == data_byte));
        end
    end

    // Shift-and update and detection of a complete match.
    assign partial_bits_next = {partial_bits_reg[PATTERN_MAX-2:0], 1'b1} & hit_mask;
    assign len_ok   = (pattern_length_reg != '0) &&
                      (pattern_length_reg <= LEN_BITS'(PATTERN_MAX));
    assign top_idx  = IDX_BITS'(pattern_length_reg - LEN_BITS'(1));
    assign full_hit = len_ok && partial_bits_next[top_idx];

    // The match starts pattern_length - 1 bytes before the current position.
    assign new_offset = byte_position_reg -
                        (OFFSET_BITS'(pattern_length_reg) - OFFSET_BITS'(1));

    // Next scan state and result.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        match_seen_next    = match_seen_reg;
        first_offset_next  = first_offset_reg;
        status_next        = ST_NONE;
        report_offset      = first_offset_reg;

        if (byte_position_reg != POS_MAX)
        begin
            byte_position_next = byte_position_reg + OFFSET_BITS'(1);
        end

        if (full_hit && !match_seen_reg)
        begin
            match_seen_next   = 1'b1;
            first_offset_next = new_offset;
            report_offset     = new_offset;
            status_next       = ST_FOUND;
        end

        if (last_byte)
        begin
            status_next        = match_seen_next ? ST_END_HIT : ST_END_MISS;
            byte_position_next = '0;
            match_seen_next    = 1'b0;
            first_offset_next  = '0;
        end

        if (cmd == CMD_LOAD)
        begin
            status_next = ST_NONE;
        end

        if ((status_next == ST_FOUND) || (status_next == ST_END_HIT))
        begin
            offset_next  = report_offset;
            address_next = base_address_reg + ADDR_BITS'(report_offset);
        end
        else
        begin
            offset_next  = '0;
            address_next = '0;
        end
    end

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_bits_reg  <= '0;
            byte_position_reg <= '0;
            match_seen_reg    <= 1'b0;
            first_offset_reg  <= '0;
        end
        else if (scan_beat)
        begin
            partial_bits_reg  <= last_byte ? '0 : partial_bits_next;
            byte_position_reg <= byte_position_next;
            match_seen_reg    <= match_seen_next;
            first_offset_reg  <= first_offset_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            status_reg  <= status_next;
            offset_reg  <= offset_next;
            address_reg <= address_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign match_offset  = offset_reg;
    assign match_address = address_reg;

    // A load beat always produces a plain status beat next cycle.
    a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (cmd == CMD_LOAD)) |=> (out_valid && (status == ST_NONE)))
        else $error("load beat did not produce a status-none result");

    // Results without a match carry zero offset and address.
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == ST_NONE) || (status == ST_END_MISS)))
        |-> ((match_offset == '0) && (match_address == '0)))
        else $error("non-match result carries a nonzero offset or address");

    // The match flag only clears on a scanned last byte.
    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(match_seen_reg) |-> $past(scan_beat && last_byte))
        else $error("match flag cleared outside the end of a scan");

    // A found report is only made when no match had been seen before.
    a_found_once: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (status_next == ST_FOUND)) |-> !match_seen_reg)
        else $error("second match reported in one scan");

endmodule
